// ===== rtl/lns_pkg.sv =====
// Shared types, codes and elaboration-time helpers for the LNS arithmetic unit.
// Holds the operation and status codes, the control word between stages and the
// functions that build the ln(1 +- e^-d) correction tables. No dependencies.
package lns_pkg;

	typedef logic [2:0] kind_t;
	typedef logic [1:0] status_t;

	localparam kind_t KIND_ADD  = 3'd0;
	localparam kind_t KIND_SUB  = 3'd1;
	localparam kind_t KIND_MUL  = 3'd2;
	localparam kind_t KIND_DIV  = 3'd3;
	localparam kind_t KIND_LESS = 3'd4;
	localparam kind_t KIND_NEG  = 3'd5;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_SAT      = 2'd1;
	localparam status_t ST_DIV_ZERO = 2'd2;

	// correction table spans d in [0, 2^RANGE_LOG2)
	localparam int RANGE_LOG2 = 4;
	// working precision of the table builder
	localparam int WFB = 30;
	localparam logic [63:0] ONE_W = 64'd1 << WFB;
	localparam longint LN2_W = 64'sd744261118;
	localparam logic [63:0] EINV_W = 64'd395007542;

	typedef struct packed {
		kind_t kind;
		logic  sign;
		logic  zero_res;
		logic  div_zero;
		logic  use_corr;
		logic  less;
	} lns_ctl_t;

	// restoring division, elaboration only
	function automatic logic [63:0] udiv(logic [63:0] num, logic [63:0] den);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int j = 63; j >= 0; j--) begin
			rem = {rem[62:0], num[j]};
			if (rem >= den) begin
				rem = rem - den;
				quo[j] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic logic [63:0] exp_neg_w(logic [63:0] x);
		logic [63:0] f;
		logic [63:0] n;
		logic [63:0] term;
		logic [63:0] v;
		longint sum;
		f = x & (ONE_W - 64'd1);
		n = x >> WFB;
		term = ONE_W;
		sum = longint'(ONE_W);
		for (int k = 1; k <= 24; k++) begin
			term = udiv((term * f) >> WFB, 64'(k));
			if (k % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		v = (sum > 0) ? 64'(sum) : 64'd0;
		for (int j = 0; j < 64; j++) begin
			if (64'(j) < n)
				v = (v * EINV_W) >> WFB;
		end
		return v;
	endfunction

	function automatic longint ln_w(logic [63:0] w_in);
		logic [63:0] w;
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] term;
		longint e;
		longint sum;
		w = (w_in == 64'd0) ? 64'd1 : w_in;
		e = 0;
		sum = 0;
		for (int j = 0; j < 64; j++) begin
			if (w < ONE_W) begin
				w = w << 1;
				e = e - 1;
			end
		end
		for (int j = 0; j < 64; j++) begin
			if (w >= (ONE_W << 1)) begin
				w = w >> 1;
				e = e + 1;
			end
		end
		z = udiv((w - ONE_W) << WFB, w + ONE_W);
		z2 = (z * z) >> WFB;
		term = z;
		for (int k = 0; k < 20; k++) begin
			sum = sum + longint'(udiv(term, 64'(2 * k + 1)));
			term = (term * z2) >> WFB;
		end
		return e * LN2_W + 2 * sum;
	endfunction

	// round half away from zero to frac_bits fraction bits
	function automatic longint to_frac(longint v, int frac_bits);
		int sh;
		logic neg;
		logic [63:0] m;
		sh = WFB - frac_bits;
		neg = v < 0;
		m = neg ? 64'(-v) : 64'(v);
		if (sh > 0)
			m = (m + (64'd1 << (sh - 1))) >> sh;
		else if (sh < 0)
			m = m << (-sh);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint corr_entry(int idx, int index_bits, int frac_bits, bit minus);
		logic [63:0] xq;
		logic [63:0] y;
		xq = 64'(2 * idx + 1) << (WFB + RANGE_LOG2 - index_bits - 1);
		y = exp_neg_w(xq);
		if (minus)
			return to_frac(ln_w((y < ONE_W) ? ONE_W - y : 64'd1), frac_bits);
		return to_frac(ln_w(ONE_W + y), frac_bits);
	endfunction

endpackage

// ===== rtl/lns_arithmetic_unit.sv =====
// Logarithmic number system arithmetic unit: add, subtract, multiply, divide,
// compare-less and negate on sign plus natural-log operands.
// Usage:
//   Drive kind, a_sign, a_log, b_sign, b_log and raise start for one cycle per
//   word; a word is taken at each rising edge with start high and busy low.
//   busy stays low: the datapath is a fixed three-register pipeline, so a new
//   word may be issued every cycle.
//   Each result appears on res_sign, res_log, res_less and res_status for one
//   cycle, marked by done, once the word has passed the input register, the
//   correction ROM read register and the result register.
//   Results leave in issue order. The receiver cannot hold results back; done
//   is a plain strobe and must be caught in the cycle it is shown.
//   A log of the most negative code stands for zero. res_status reports
//   saturation of the result log and division by zero.
//   Reset clears the pipeline valid flags and done at once; no clearing pass.
// Depends on lns_pkg, lns_front, lns_corr_rom and lns_back.
module lns_arithmetic_unit #(
	parameter int LOG_WIDTH        = 24,
	parameter int FRAC_BITS        = 12,
	parameter int TABLE_INDEX_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  lns_pkg::kind_t                kind,
	input  logic                          a_sign,
	input  logic signed [LOG_WIDTH-1:0]   a_log,
	input  logic                          b_sign,
	input  logic signed [LOG_WIDTH-1:0]   b_log,
	output logic                          done,
	output logic                          res_sign,
	output logic signed [LOG_WIDTH-1:0]   res_log,
	output logic                          res_less,
	output lns_pkg::status_t              res_status
);
	import lns_pkg::*;

	localparam logic signed [LOG_WIDTH-1:0] ZERO_CODE = {1'b1, {(LOG_WIDTH-1){1'b0}}};
	localparam logic signed [LOG_WIDTH-1:0] MAX_CODE  = {1'b0, {(LOG_WIDTH-1){1'b1}}};
	localparam logic signed [LOG_WIDTH-1:0] MIN_CODE  = {1'b1, {(LOG_WIDTH-2){1'b0}}, 1'b1};

	logic                        valid_s1;
	kind_t                       kind_s1;
	logic                        a_sign_s1;
	logic signed [LOG_WIDTH-1:0] a_log_s1;
	logic                        b_sign_s1;
	logic signed [LOG_WIDTH-1:0] b_log_s1;

	lns_ctl_t                    ctl;
	logic signed [LOG_WIDTH:0]   opnd;
	logic [TABLE_INDEX_BITS:0]   rom_addr;

	logic                        valid_s2;
	lns_ctl_t                    ctl_s2;
	logic signed [LOG_WIDTH:0]   opnd_s2;
	logic signed [FRAC_BITS+5:0] corr_s2;

	logic                        nxt_sign;
	logic signed [LOG_WIDTH-1:0] nxt_log;
	logic                        nxt_less;
	status_t                     nxt_status;

	logic                        done_q;
	logic                        res_sign_q;
	logic signed [LOG_WIDTH-1:0] res_log_q;
	logic                        res_less_q;
	status_t                     res_status_q;

	assign busy = 1'b0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			kind_s1   <= kind;
			a_sign_s1 <= a_sign;
			a_log_s1  <= a_log;
			b_sign_s1 <= b_sign;
			b_log_s1  <= b_log;
		end
	end

	lns_front #(
		.LOG_WIDTH        (LOG_WIDTH),
		.FRAC_BITS        (FRAC_BITS),
		.TABLE_INDEX_BITS (TABLE_INDEX_BITS)
	) u_front (
		.kind     (kind_s1),
		.a_sign   (a_sign_s1),
		.a_log    (a_log_s1),
		.b_sign   (b_sign_s1),
		.b_log    (b_log_s1),
		.ctl      (ctl),
		.opnd     (opnd),
		.rom_addr (rom_addr)
	);

	lns_corr_rom #(
		.FRAC_BITS        (FRAC_BITS),
		.TABLE_INDEX_BITS (TABLE_INDEX_BITS)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.corr (corr_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s2  <= ctl;
		opnd_s2 <= opnd;
	end

	lns_back #(
		.LOG_WIDTH (LOG_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.ctl        (ctl_s2),
		.opnd       (opnd_s2),
		.corr       (corr_s2),
		.res_sign   (nxt_sign),
		.res_log    (nxt_log),
		.res_less   (nxt_less),
		.res_status (nxt_status)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		res_sign_q   <= nxt_sign;
		res_log_q    <= nxt_log;
		res_less_q   <= nxt_less;
		res_status_q <= nxt_status;
	end

	assign done       = done_q;
	assign res_sign   = res_sign_q;
	assign res_log    = res_log_q;
	assign res_less   = res_less_q;
	assign res_status = res_status_q;

	a_issue_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##2 done)
		else $error("word taken but no result three cycles later");

	a_done_has_issue: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 3))
		else $error("result shown with no word taken three cycles before");

	a_div_zero_max: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res_status == ST_DIV_ZERO) |-> res_log == MAX_CODE)
		else $error("divide by zero without saturated log");

	a_sat_code: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res_status == ST_SAT) |-> (res_log == MAX_CODE || res_log == MIN_CODE))
		else $error("saturation flagged on an unclamped log");

	a_less_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res_less) |-> (res_log == ZERO_CODE && !res_sign && res_status == ST_OK))
		else $error("compare result carries a nonzero value");

endmodule

// ===== rtl/lns_corr_rom.sv =====
// Correction ROM: ln(1 + e^-d) in the lower half, ln(1 - e^-d) in the upper half.
// Contents are built at elaboration from lns_pkg functions; read data is registered.
// Depends on lns_pkg.
module lns_corr_rom #(
	parameter int FRAC_BITS        = 12,
	parameter int TABLE_INDEX_BITS = 10
) (
	input  logic                          clk,
	input  logic [TABLE_INDEX_BITS:0]     addr,
	output logic signed [FRAC_BITS+5:0]   corr
);
	import lns_pkg::*;

	localparam int CORR_W = FRAC_BITS + 6;
	localparam int TBL    = 1 << TABLE_INDEX_BITS;
	localparam int DEPTH  = 2 * TBL;

	logic signed [CORR_W-1:0] rom [DEPTH];
	logic signed [CORR_W-1:0] corr_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_entry
		localparam longint V = corr_entry(i % TBL, TABLE_INDEX_BITS, FRAC_BITS, i >= TBL);
		assign rom[i] = V[CORR_W-1:0];
	end

	always_ff @(posedge clk) begin
		corr_q <= rom[addr];
	end

	assign corr = corr_q;

endmodule

// ===== rtl/lns_front.sv =====
// First stage of the LNS unit: zero detect, magnitude compare, log difference,
// table address, mul/div log sum or difference and compare result. Pure combinational.
// Depends on lns_pkg.
module lns_front #(
	parameter int LOG_WIDTH        = 24,
	parameter int FRAC_BITS        = 12,
	parameter int TABLE_INDEX_BITS = 10
) (
	input  lns_pkg::kind_t                kind,
	input  logic                          a_sign,
	input  logic signed [LOG_WIDTH-1:0]   a_log,
	input  logic                          b_sign,
	input  logic signed [LOG_WIDTH-1:0]   b_log,
	output lns_pkg::lns_ctl_t             ctl,
	output logic signed [LOG_WIDTH:0]     opnd,
	output logic [TABLE_INDEX_BITS:0]     rom_addr
);
	import lns_pkg::*;

	localparam int RANGE_SH = FRAC_BITS + RANGE_LOG2;
	localparam int IDX_SH   = FRAC_BITS + RANGE_LOG2 - TABLE_INDEX_BITS;
	localparam logic signed [LOG_WIDTH-1:0] ZERO_CODE = {1'b1, {(LOG_WIDTH-1){1'b0}}};

	logic za;
	logic zb;
	logic b_sign_eff;
	logic a_ge;
	logic signed [LOG_WIDTH:0] a_ext;
	logic signed [LOG_WIDTH:0] b_ext;
	logic signed [LOG_WIDTH:0] diff;
	logic [LOG_WIDTH-1:0] d;
	logic [LOG_WIDTH+TABLE_INDEX_BITS-1:0] d_wide;
	logic [TABLE_INDEX_BITS-1:0] idx;
	logic in_range;
	logic big_sign;
	logic ea;
	logic eb;
	logic less;

	assign za = a_log == ZERO_CODE;
	assign zb = b_log == ZERO_CODE;
	assign b_sign_eff = (kind == KIND_SUB) ? ~b_sign : b_sign;
	assign a_ext = {a_log[LOG_WIDTH-1], a_log};
	assign b_ext = {b_log[LOG_WIDTH-1], b_log};
	assign a_ge = a_log >= b_log;
	assign diff = a_ge ? a_ext - b_ext : b_ext - a_ext;
	assign d = diff[LOG_WIDTH-1:0];
	assign d_wide = {{TABLE_INDEX_BITS{1'b0}}, d};
	assign in_range = (d >> RANGE_SH) == '0;
	assign big_sign = a_ge ? a_sign : b_sign_eff;

	if (IDX_SH >= 0) begin : g_idx_down
		assign idx = TABLE_INDEX_BITS'(d_wide >> IDX_SH);
	end else begin : g_idx_up
		assign idx = TABLE_INDEX_BITS'(d_wide << (-IDX_SH));
	end

	assign rom_addr = {a_sign != b_sign_eff, idx};

	// zero counts as positive whatever its sign bit
	assign ea = ~za & a_sign;
	assign eb = ~zb & b_sign;

	always_comb begin
		if (ea && !eb)
			less = 1'b1;
		else if (!ea && eb)
			less = 1'b0;
		else if (!ea)
			less = a_log < b_log;
		else
			less = a_log > b_log;
	end

	always_comb begin
		ctl.kind     = kind;
		ctl.sign     = 1'b0;
		ctl.zero_res = 1'b0;
		ctl.div_zero = 1'b0;
		ctl.use_corr = 1'b0;
		ctl.less     = 1'b0;
		opnd         = '0;
		case (kind) inside
			KIND_ADD, KIND_SUB: begin
				opnd         = a_ge ? a_ext : b_ext;
				ctl.sign     = big_sign;
				// both zero, or equal magnitudes cancelling
				ctl.zero_res = (a_log == b_log) && (za || (a_sign != b_sign_eff));
				ctl.use_corr = ~za & ~zb & in_range;
			end
			KIND_MUL: begin
				opnd         = a_ext + b_ext;
				ctl.sign     = a_sign ^ b_sign;
				ctl.zero_res = za | zb;
			end
			KIND_DIV: begin
				opnd         = a_ext - b_ext;
				ctl.sign     = a_sign ^ b_sign;
				ctl.zero_res = za;
				ctl.div_zero = zb;
			end
			KIND_LESS: begin
				ctl.less = less;
			end
			KIND_NEG: begin
				opnd     = a_ext;
				ctl.sign = ~za & ~a_sign;
			end
			default: begin
				ctl.kind = kind;
			end
		endcase
	end

endmodule

// ===== rtl/lns_back.sv =====
// Second stage of the LNS unit: add the table correction, saturate and
// select the result fields for each operation. Pure combinational.
// Depends on lns_pkg.
module lns_back #(
	parameter int LOG_WIDTH = 24,
	parameter int FRAC_BITS = 12
) (
	input  lns_pkg::lns_ctl_t             ctl,
	input  logic signed [LOG_WIDTH:0]     opnd,
	input  logic signed [FRAC_BITS+5:0]   corr,
	output logic                          res_sign,
	output logic signed [LOG_WIDTH-1:0]   res_log,
	output logic                          res_less,
	output lns_pkg::status_t              res_status
);
	import lns_pkg::*;

	localparam int CORR_W = FRAC_BITS + 6;
	localparam int SUM_W  = ((LOG_WIDTH + 1 > CORR_W) ? LOG_WIDTH + 1 : CORR_W) + 1;
	localparam logic signed [LOG_WIDTH-1:0] ZERO_CODE = {1'b1, {(LOG_WIDTH-1){1'b0}}};
	localparam logic signed [LOG_WIDTH-1:0] MAX_CODE  = {1'b0, {(LOG_WIDTH-1){1'b1}}};
	localparam logic signed [LOG_WIDTH-1:0] MIN_CODE  = {1'b1, {(LOG_WIDTH-2){1'b0}}, 1'b1};
	localparam logic signed [SUM_W-1:0] MAX_S =
		{{(SUM_W-LOG_WIDTH+1){1'b0}}, {(LOG_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] MIN_S =
		{{(SUM_W-LOG_WIDTH+1){1'b1}}, {(LOG_WIDTH-2){1'b0}}, 1'b1};

	logic signed [SUM_W-1:0] val;

	assign val = SUM_W'(opnd) + (ctl.use_corr ? SUM_W'(corr) : '0);

	always_comb begin
		res_sign   = 1'b0;
		res_log    = '0;
		res_less   = 1'b0;
		res_status = ST_OK;
		case (ctl.kind) inside
			KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
				if (ctl.div_zero) begin
					res_sign   = ctl.sign;
					res_log    = MAX_CODE;
					res_status = ST_DIV_ZERO;
				end else if (ctl.zero_res) begin
					res_log = ZERO_CODE;
				end else if (val > MAX_S) begin
					res_sign   = ctl.sign;
					res_log    = MAX_CODE;
					res_status = ST_SAT;
				end else if (val < MIN_S) begin
					// clamp to the smallest nonzero magnitude
					res_sign   = ctl.sign;
					res_log    = MIN_CODE;
					res_status = ST_SAT;
				end else begin
					res_sign = ctl.sign;
					res_log  = val[LOG_WIDTH-1:0];
				end
			end
			KIND_LESS: begin
				res_log  = ZERO_CODE;
				res_less = ctl.less;
			end
			KIND_NEG: begin
				res_sign = ctl.sign;
				res_log  = opnd[LOG_WIDTH-1:0];
			end
			default: begin
				res_log = '0;
			end
		endcase
	end

endmodule

// ===== bench/tb_lns_arithmetic_unit.sv =====
// Self-checking bench for lns_arithmetic_unit: directed corner words, then random
// operand pairs, checked against a local model with its own correction tables.
// Depends on lns_pkg and the unit under test; reads no files.
module tb_lns_arithmetic_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import lns_pkg::*;

	localparam int LW        = 24;
	localparam int FB        = 12;
	localparam int TIB       = 10;
	localparam int SPAN_LOG2 = 4;
	localparam int WORK_FRAC = 30;
	localparam int TBL_ENTRIES = 1 << TIB;
	localparam int CYCLE_LIMIT = 200000;

	typedef longint unsigned u64_t;

	localparam u64_t   Q30_ONE  = 64'd1 << WORK_FRAC;
	localparam u64_t   EINV_Q30 = 64'd395007542;
	localparam longint LN2_Q30  = 64'sd744261118;

	localparam longint LOG_ZERO_L = -(longint'(1) << (LW - 1));
	localparam longint LOG_MAX_L  = (longint'(1) << (LW - 1)) - 1;
	localparam logic [LW-1:0] LOG_ZERO = {1'b1, {(LW-1){1'b0}}};
	localparam logic [LW-1:0] LOG_MAX  = {1'b0, {(LW-1){1'b1}}};
	localparam logic [LW-1:0] LOG_TINY = LOG_ZERO + 1'b1;

	// codes the unit does not decode
	localparam kind_t KIND_SPARE6 = 3'd6;
	localparam kind_t KIND_SPARE7 = 3'd7;

	typedef struct packed {
		logic          sign;
		logic [LW-1:0] lg;
		logic          less;
		status_t       st;
	} lns_word_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 start  = 1'b0;
	kind_t                kind   = KIND_ADD;
	logic                 a_sign = 1'b0;
	logic signed [LW-1:0] a_log  = '0;
	logic                 b_sign = 1'b0;
	logic signed [LW-1:0] b_log  = '0;
	logic                 busy;
	logic                 done;
	logic                 res_sign;
	logic signed [LW-1:0] res_log;
	logic                 res_less;
	status_t              res_status;

	longint    ln_one_plus  [TBL_ENTRIES];
	longint    ln_one_minus [TBL_ENTRIES];
	lns_word_t pending_results[$];
	int        mismatches = 0;
	int        cycle_count = 0;
	bit        gaps_on = 1'b1;

	lns_arithmetic_unit #(
		.LOG_WIDTH       (LW),
		.FRAC_BITS       (FB),
		.TABLE_INDEX_BITS(TIB)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.a_sign    (a_sign),
		.a_log     (a_log),
		.b_sign    (b_sign),
		.b_log     (b_log),
		.done      (done),
		.res_sign  (res_sign),
		.res_log   (res_log),
		.res_less  (res_less),
		.res_status(res_status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_lns_arithmetic_unit: errors");
			$finish;
		end
	end

	// e^-x in Q.30: series on the fraction, then one e^-1 factor per whole unit
	function automatic u64_t q30_exp_neg(u64_t x);
		u64_t   frac_part;
		u64_t   whole;
		u64_t   term;
		u64_t   v;
		longint acc;
		frac_part = x & (Q30_ONE - 1);
		whole = x >> WORK_FRAC;
		term = Q30_ONE;
		acc = longint'(Q30_ONE);
		for (int k = 1; k <= 24; k++) begin
			term = ((term * frac_part) >> WORK_FRAC) / u64_t'(k);
			if (k % 2 == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		v = (acc > 0) ? u64_t'(acc) : 64'd0;
		while (whole > 0) begin
			v = (v * EINV_Q30) >> WORK_FRAC;
			whole--;
		end
		return v;
	endfunction

	// ln in Q.30: normalise to [1,2), then 2*atanh((w-1)/(w+1))
	function automatic longint q30_ln(u64_t w_in);
		u64_t   w;
		u64_t   z;
		u64_t   z2;
		u64_t   term;
		longint e;
		longint acc;
		w = (w_in == 0) ? 64'd1 : w_in;
		e = 0;
		acc = 0;
		while (w < Q30_ONE) begin
			w = w << 1;
			e--;
		end
		while (w >= 2 * Q30_ONE) begin
			w = w >> 1;
			e++;
		end
		z = ((w - Q30_ONE) << WORK_FRAC) / (w + Q30_ONE);
		z2 = (z * z) >> WORK_FRAC;
		term = z;
		for (int k = 0; k < 20; k++) begin
			acc = acc + longint'(term / u64_t'(2 * k + 1));
			term = (term * z2) >> WORK_FRAC;
		end
		return e * LN2_Q30 + 2 * acc;
	endfunction

	function automatic longint round_to_log_frac(longint v);
		logic neg;
		u64_t m;
		neg = v < 0;
		m = neg ? u64_t'(-v) : u64_t'(v);
		m = (m + (u64_t'(1) << (WORK_FRAC - FB - 1))) >> (WORK_FRAC - FB);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic void build_corr_tables();
		u64_t xq;
		u64_t y;
		for (int i = 0; i < TBL_ENTRIES; i++) begin
			// sample each bin at its midpoint
			xq = u64_t'(2 * i + 1) << (WORK_FRAC + SPAN_LOG2 - TIB - 1);
			y = q30_exp_neg(xq);
			ln_one_plus[i] = round_to_log_frac(q30_ln(Q30_ONE + y));
			ln_one_minus[i] = round_to_log_frac(q30_ln((y < Q30_ONE) ? Q30_ONE - y : 64'd1));
		end
	endfunction

	function automatic longint clamp_log(longint v, output logic hit);
		hit = 1'b1;
		if (v > LOG_MAX_L)
			return LOG_MAX_L;
		if (v < LOG_ZERO_L + 1)
			return LOG_ZERO_L + 1;
		hit = 1'b0;
		return v;
	endfunction

	function automatic lns_word_t predict_lns(kind_t k, logic sa, logic signed [LW-1:0] la,
			logic sb, logic signed [LW-1:0] lb);
		lns_word_t r;
		longint    a_v;
		longint    b_v;
		longint    rl;
		longint    big;
		longint    d;
		longint    corr;
		logic      rs;
		logic      sbe;
		logic      big_sign;
		logic      za;
		logic      zb;
		logic      ea;
		logic      eb;
		logic      hit;
		logic      less_bit;
		status_t   st;
		a_v = la;
		b_v = lb;
		za = a_v == LOG_ZERO_L;
		zb = b_v == LOG_ZERO_L;
		rs = 1'b0;
		rl = LOG_ZERO_L;
		less_bit = 1'b0;
		st = ST_OK;
		case (k) inside
			KIND_ADD, KIND_SUB: begin
				sbe = (k == KIND_SUB) ? ~sb : sb;
				if (za && zb) begin
					rl = LOG_ZERO_L;
				end else if (za) begin
					rs = sbe;
					rl = b_v;
				end else if (zb) begin
					rs = sa;
					rl = a_v;
				end else begin
					big = (a_v >= b_v) ? a_v : b_v;
					d = (a_v >= b_v) ? a_v - b_v : b_v - a_v;
					big_sign = (a_v >= b_v) ? sa : sbe;
					// equal magnitudes of opposite sign cancel exactly
					if (sa != sbe && d == 0) begin
						rl = LOG_ZERO_L;
					end else begin
						corr = 0;
						if (d < (longint'(1) << (FB + SPAN_LOG2))) begin
							if (sa == sbe)
								corr = ln_one_plus[TIB'(d >>> (FB + SPAN_LOG2 - TIB))];
							else
								corr = ln_one_minus[TIB'(d >>> (FB + SPAN_LOG2 - TIB))];
						end
						rs = big_sign;
						rl = clamp_log(big + corr, hit);
						if (hit)
							st = ST_SAT;
					end
				end
			end
			KIND_MUL: begin
				if (!za && !zb) begin
					rs = sa ^ sb;
					rl = clamp_log(a_v + b_v, hit);
					if (hit)
						st = ST_SAT;
				end
			end
			KIND_DIV: begin
				if (zb) begin
					rs = sa ^ sb;
					rl = LOG_MAX_L;
					st = ST_DIV_ZERO;
				end else if (!za) begin
					rs = sa ^ sb;
					rl = clamp_log(a_v - b_v, hit);
					if (hit)
						st = ST_SAT;
				end
			end
			KIND_LESS: begin
				// a zero counts as positive whatever its sign bit
				ea = za ? 1'b0 : sa;
				eb = zb ? 1'b0 : sb;
				if (ea && !eb)
					less_bit = 1'b1;
				else if (!ea && eb)
					less_bit = 1'b0;
				else if (!ea)
					less_bit = a_v < b_v;
				else
					less_bit = a_v > b_v;
			end
			KIND_NEG: begin
				rl = a_v;
				rs = za ? 1'b0 : ~sa;
			end
			default: begin
				rl = 0;
			end
		endcase
		if (rl == LOG_ZERO_L && k != KIND_NEG)
			rs = 1'b0;
		r.sign = rs;
		r.lg = rl[LW-1:0];
		r.less = less_bit;
		r.st = st;
		return r;
	endfunction

	// call at a rising edge; returns at the edge that took the word
	task automatic send_word(kind_t k, logic sa, logic [LW-1:0] la, logic sb, logic [LW-1:0] lb);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		a_sign <= sa;
		a_log <= la;
		b_sign <= sb;
		b_log <= lb;
		do
			@(posedge clk);
		while (busy);
		pending_results = {pending_results, predict_lns(k, sa, la, sb, lb)};
	endtask

	always @(posedge clk) begin
		lns_word_t got;
		lns_word_t want;
		if (arst_n && done) begin
			got = {res_sign, res_log, res_less, res_status};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: sign %0b log %0d less %0b status %0d",
						got.sign, $signed(got.lg), got.less, got.st);
			end else begin
				want = pending_results.pop_front();
				if (got.sign !== want.sign || got.lg !== want.lg
						|| got.less !== want.less || got.st !== want.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch sign/log/less/status: want %0b/%0d/%0b/%0d, got %0b/%0d/%0b/%0d",
							want.sign, $signed(want.lg), want.less, want.st,
							got.sign, $signed(got.lg), got.less, got.st);
				end
			end
		end
	end

	function automatic logic [LW-1:0] rand_log();
		case ($urandom_range(0, 9))
			0: return LOG_ZERO;
			1: return $urandom_range(0, 1) ? LOG_MAX : LOG_TINY;
			2, 3, 4: return LW'($urandom());
			default: return LW'($urandom_range(0, 1 << 17) - (1 << 16));
		endcase
	endfunction

	// most pairs land close together so the table is exercised
	function automatic void pick_operands(output logic sa, output logic [LW-1:0] la,
			output logic sb, output logic [LW-1:0] lb);
		sa = $urandom_range(0, 1);
		sb = $urandom_range(0, 1);
		la = rand_log();
		case ($urandom_range(0, 4))
			0, 1: lb = la + LW'($urandom_range(0, 140000) - 70000);
			2: lb = la;
			default: lb = rand_log();
		endcase
	endfunction

	task automatic test_special_cases();
		send_word(KIND_ADD, 1'b0, LW'(0), 1'b0, LW'(0));
		send_word(KIND_SUB, 1'b0, LW'(0), 1'b0, LW'(0));
		send_word(KIND_ADD, 1'b0, LW'(5000), 1'b1, LW'(5000));
		send_word(KIND_ADD, 1'b1, LOG_ZERO, 1'b1, LW'(1234));
		send_word(KIND_SUB, 1'b1, LW'(-777), 1'b0, LOG_ZERO);
		send_word(KIND_SUB, 1'b0, LOG_ZERO, 1'b0, LW'(4321));
		send_word(KIND_ADD, 1'b1, LOG_ZERO, 1'b1, LOG_ZERO);
		send_word(KIND_ADD, 1'b0, LOG_MAX, 1'b0, LOG_MAX);
		send_word(KIND_ADD, 1'b0, LW'(0), 1'b0, LW'(-(1 << 16)));
		send_word(KIND_ADD, 1'b1, LW'(0), 1'b1, LW'(-((1 << 16) - 1)));
		send_word(KIND_ADD, 1'b0, LW'(1), 1'b1, LW'(0));
		send_word(KIND_SUB, 1'b0, LOG_TINY + 1'b1, 1'b0, LOG_TINY);
		send_word(KIND_MUL, 1'b1, LOG_MAX, 1'b0, LOG_MAX);
		send_word(KIND_MUL, 1'b1, LOG_TINY, 1'b1, LOG_TINY);
		send_word(KIND_MUL, 1'b1, LOG_ZERO, 1'b0, LW'(100));
		send_word(KIND_DIV, 1'b1, LW'(2000), 1'b0, LOG_ZERO);
		send_word(KIND_DIV, 1'b0, LOG_ZERO, 1'b1, LOG_ZERO);
		send_word(KIND_DIV, 1'b1, LOG_ZERO, 1'b1, LW'(300));
		send_word(KIND_DIV, 1'b0, LOG_TINY, 1'b0, LOG_MAX);
		send_word(KIND_LESS, 1'b1, LOG_ZERO, 1'b0, LOG_ZERO);
		send_word(KIND_LESS, 1'b1, LW'(10), 1'b0, LW'(-10));
		send_word(KIND_LESS, 1'b1, LW'(10), 1'b1, LW'(-10));
		send_word(KIND_LESS, 1'b0, LW'(77), 1'b0, LW'(77));
		send_word(KIND_NEG, 1'b0, LW'(555), 1'b1, LW'(0));
		send_word(KIND_NEG, 1'b1, LOG_ZERO, 1'b0, LW'(0));
		send_word(KIND_SPARE6, 1'b1, '1, 1'b1, '1);
		send_word(KIND_SPARE7, 1'b1, LOG_MAX, 1'b1, LOG_ZERO);
	endtask

	task automatic test_random_arith(int count);
		logic          sa;
		logic          sb;
		logic [LW-1:0] la;
		logic [LW-1:0] lb;
		for (int i = 0; i < count; i++) begin
			pick_operands(sa, la, sb, lb);
			send_word(kind_t'($urandom_range(0, 3)), sa, la, sb, lb);
		end
	endtask

	task automatic test_random_mixed(int count);
		logic          sa;
		logic          sb;
		logic [LW-1:0] la;
		logic [LW-1:0] lb;
		for (int i = 0; i < count; i++) begin
			pick_operands(sa, la, sb, lb);
			send_word(kind_t'($urandom_range(0, 7)), sa, la, sb, lb);
		end
	endtask

	task automatic test_back_to_back(int count);
		gaps_on = 1'b0;
		test_random_mixed(count);
	endtask

	initial begin
		int waited;
		build_corr_tables();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_special_cases();
		test_random_arith(350);
		test_random_mixed(300);
		test_back_to_back(150);
		start <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		mismatches += pending_results.size();
		if (mismatches == 0)
			$display("tb_lns_arithmetic_unit: clean");
		else
			$display("tb_lns_arithmetic_unit: errors");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lns_pkg.sv
rtl/lns_corr_rom.sv
rtl/lns_front.sv
rtl/lns_back.sv
rtl/lns_arithmetic_unit.sv
bench/tb_lns_arithmetic_unit.sv
